// ===== rtl/core/mpbfs_pkg.sv =====
package mpbfs_pkg;

    // fixed field widths
    localparam int COMP_W  = 16;
    localparam int FRAME_W = 7;
    localparam int ERR_W   = 44;
    localparam int ALPHA_W = 8;

    localparam int DEF_PIXEL_BITS = 16;

    // frame counter wraps to zero at this count
    localparam int MAX_FRAMES = 128;

    // alpha code that marks a background pixel
    localparam logic [ALPHA_W-1:0] ALPHA_BLOCK = 8'hFF;

    // empty / saturated error value
    localparam logic [ERR_W-1:0] ERR_EMPTY = '1;

    // per-pixel control carried alongside the lane data
    typedef struct packed {
        logic fill;
        logic blocked;
        logic close;
        logic send;
    } pix_ctrl_t;

    // merge stage status seen by the stall logic
    typedef struct packed {
        logic s2_valid;
        logic s2_send;
    } merge_stat_t;

    typedef struct packed {
        logic [FRAME_W-1:0] best_frame;
        logic [ERR_W-1:0]   best_error;
        logic               found;
    } result_t;

endpackage

// ===== rtl/core/mpbfs_pix_if.sv =====
interface mpbfs_pix_if
    import mpbfs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COMP_W-1:0]  probe_red;
    logic [COMP_W-1:0]  probe_green;
    logic [COMP_W-1:0]  probe_blue;
    logic [COMP_W-1:0]  cand_red;
    logic [COMP_W-1:0]  cand_green;
    logic [COMP_W-1:0]  cand_blue;
    logic               to_fill;
    logic [ALPHA_W-1:0] alpha_byte;
    logic               patch_end;
    logic               search_end;

    modport source (
        output valid, probe_red, probe_green, probe_blue,
        output cand_red, cand_green, cand_blue,
        output to_fill, alpha_byte, patch_end, search_end,
        input  ready
    );

    modport sink (
        input  valid, probe_red, probe_green, probe_blue,
        input  cand_red, cand_green, cand_blue,
        input  to_fill, alpha_byte, patch_end, search_end,
        output ready
    );
endinterface

// ===== rtl/core/mpbfs_res_if.sv =====
interface mpbfs_res_if
    import mpbfs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] best_frame;
    logic [ERR_W-1:0]   best_error;
    logic               found;

    modport source (
        output valid, best_frame, best_error, found,
        input  ready
    );

    modport sink (
        input  valid, best_frame, best_error, found,
        output ready
    );
endinterface

// ===== rtl/core/mpbfs_sq_lane.sv =====
module mpbfs_sq_lane
    import mpbfs_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [COMP_W-1:0]       probe,
    input  logic [COMP_W-1:0]       cand,
    output logic [2*PIXEL_BITS-1:0] sq
);

    logic [PIXEL_BITS-1:0]   a;
    logic [PIXEL_BITS-1:0]   b;
    logic [PIXEL_BITS-1:0]   diff;
    logic [2*PIXEL_BITS-1:0] sq_reg;
    logic [2*PIXEL_BITS-1:0] sq_next;

    assign a = probe[PIXEL_BITS-1:0];
    assign b = cand[PIXEL_BITS-1:0];

    always_comb
    begin
        diff    = (a >= b) ? (a - b) : (b - a);
        sq_next = (2*PIXEL_BITS)'(diff) * (2*PIXEL_BITS)'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

// ===== rtl/core/mpbfs_merge.sv =====
module mpbfs_merge
    import mpbfs_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    s1_valid,
    input  pix_ctrl_t               s1_ctrl,
    input  logic [2*PIXEL_BITS-1:0] sq_r,
    input  logic [2*PIXEL_BITS-1:0] sq_g,
    input  logic [2*PIXEL_BITS-1:0] sq_b,
    input  logic                    start_load,
    input  logic [FRAME_W-1:0]      start_frame,
    output merge_stat_t             stat,
    output result_t                 res,
    output logic                    res_strobe
);

    localparam int SUM_W = 2*PIXEL_BITS + 2;

    // lane sum stage
    logic               s2_valid_reg;
    pix_ctrl_t          s2_ctrl_reg;
    logic [SUM_W-1:0]   e_reg;
    logic [SUM_W-1:0]   e_next;

    // search state
    logic [ERR_W-1:0]   patch_error_reg;
    logic [ERR_W-1:0]   patch_error_next;
    logic               patch_blocked_reg;
    logic               patch_blocked_next;
    logic [ERR_W-1:0]   lowest_error_reg;
    logic [ERR_W-1:0]   lowest_error_next;
    logic [FRAME_W-1:0] lowest_frame_reg;
    logic [FRAME_W-1:0] lowest_frame_next;
    logic [FRAME_W-1:0] frame_counter_reg;
    logic [FRAME_W-1:0] frame_counter_next;
    logic               any_found_reg;
    logic               any_found_next;

    logic [ERR_W:0]     acc_sum;
    logic [ERR_W-1:0]   acc_sat;
    logic               blk_now;
    logic               win;
    logic               step;
    logic [ERR_W-1:0]   cand_error;
    logic [FRAME_W-1:0] cand_frame;
    logic               cand_found;
    logic [FRAME_W:0]   fc_inc;
    logic [FRAME_W-1:0] fc_wrap;

    always_comb
    begin
        e_next = SUM_W'(sq_r) + SUM_W'(sq_g) + SUM_W'(sq_b);
        if (!s1_ctrl.fill)
        begin
            e_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid;
            s2_ctrl_reg  <= s1_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg <= e_next;
        end
    end

    // accumulate, saturate and compare at frame close
    always_comb
    begin
        step       = adv && s2_valid_reg;
        acc_sum    = {1'b0, patch_error_reg} + (ERR_W+1)'(e_reg);
        acc_sat    = acc_sum[ERR_W] ? ERR_EMPTY : acc_sum[ERR_W-1:0];
        blk_now    = patch_blocked_reg | s2_ctrl_reg.blocked;
        win        = s2_ctrl_reg.close && !blk_now && (acc_sat < lowest_error_reg);
        cand_error = win ? acc_sat : lowest_error_reg;
        cand_frame = win ? frame_counter_reg : lowest_frame_reg;
        cand_found = win | any_found_reg;
        fc_inc     = {1'b0, frame_counter_reg} + (FRAME_W+1)'(1);
        fc_wrap    = (fc_inc >= (FRAME_W+1)'(MAX_FRAMES)) ? '0 : fc_inc[FRAME_W-1:0];
    end

    always_comb
    begin
        patch_error_next   = patch_error_reg;
        patch_blocked_next = patch_blocked_reg;
        lowest_error_next  = lowest_error_reg;
        lowest_frame_next  = lowest_frame_reg;
        any_found_next     = any_found_reg;
        frame_counter_next = frame_counter_reg;
        if (step)
        begin
            patch_error_next   = acc_sat;
            patch_blocked_next = blk_now;
            if (s2_ctrl_reg.close)
            begin
                patch_error_next   = '0;
                patch_blocked_next = 1'b0;
                lowest_error_next  = cand_error;
                lowest_frame_next  = cand_frame;
                any_found_next     = cand_found;
                frame_counter_next = fc_wrap;
            end
            if (s2_ctrl_reg.send)
            begin
                lowest_error_next  = ERR_EMPTY;
                lowest_frame_next  = '0;
                any_found_next     = 1'b0;
                frame_counter_next = start_frame;
            end
        end
        if (start_load)
        begin
            frame_counter_next = start_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_error_reg   <= '0;
            patch_blocked_reg <= 1'b0;
            lowest_error_reg  <= ERR_EMPTY;
            lowest_frame_reg  <= '0;
            any_found_reg     <= 1'b0;
            frame_counter_reg <= '0;
        end
        else
        begin
            patch_error_reg   <= patch_error_next;
            patch_blocked_reg <= patch_blocked_next;
            lowest_error_reg  <= lowest_error_next;
            lowest_frame_reg  <= lowest_frame_next;
            any_found_reg     <= any_found_next;
            frame_counter_reg <= frame_counter_next;
        end
    end

    always_comb
    begin
        res.best_frame  = cand_found ? cand_frame : '0;
        res.best_error  = cand_found ? cand_error : ERR_EMPTY;
        res.found       = cand_found;
        res_strobe      = step && s2_ctrl_reg.send;
        stat.s2_valid   = s2_valid_reg;
        stat.s2_send    = s2_ctrl_reg.send;
    end

endmodule

// ===== rtl/core/masked_patch_best_frame_search_core.sv =====
// result path: a search result is registered in order through lane square, lane merge
//   and accumulate/compare after the request carrying search_end is accepted
// throughput: one pixel request per cycle; input stalls only while a finished
//   result is untaken and the next search end has reached the compare stage
// reset: rst_n asynchronous active low; start_frame and frame counter go to 0,
//   best error to all ones, pipeline and result register empty
module masked_patch_best_frame_search_core
    import mpbfs_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [FRAME_W-1:0] cfg_wdata,
    mpbfs_pix_if.sink          pixel,
    mpbfs_res_if.source        result
);

    // configuration
    logic [FRAME_W-1:0] start_frame_reg;
    // frame number the merge stage loads: the new value during a write,
    // the stored start frame when a search restarts
    logic [FRAME_W-1:0] start_sel;

    // lane stage control, payload lives in the lanes
    logic               s1_valid_reg;
    pix_ctrl_t          s1_ctrl_reg;
    pix_ctrl_t          s1_ctrl_next;

    logic [2*PIXEL_BITS-1:0] sq_r;
    logic [2*PIXEL_BITS-1:0] sq_g;
    logic [2*PIXEL_BITS-1:0] sq_b;

    merge_stat_t        stat;
    result_t            res;
    logic               res_strobe;

    // output register
    logic               res_valid_reg;
    logic               res_valid_next;
    result_t            res_reg;
    result_t            res_next;

    // whole pipeline moves together; it holds only when a search end
    // would overwrite a result that is still waiting
    logic               adv;

    assign adv         = !(stat.s2_valid && stat.s2_send && res_valid_reg && !result.ready);
    assign pixel.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_frame_reg <= '0;
        end
        else if (cfg_we)
        begin
            start_frame_reg <= cfg_wdata;
        end
    end

    assign start_sel = cfg_we ? cfg_wdata : start_frame_reg;

    // per-pixel flags for the merge stage
    always_comb
    begin
        s1_ctrl_next.fill    = pixel.to_fill;
        s1_ctrl_next.blocked = (pixel.alpha_byte == ALPHA_BLOCK);
        s1_ctrl_next.close   = pixel.patch_end | pixel.search_end;  // search end closes too
        s1_ctrl_next.send    = pixel.search_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pixel.valid;
            s1_ctrl_reg  <= s1_ctrl_next;
        end
    end

    // one squaring lane per color channel
    mpbfs_sq_lane #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_lane_r (
        .clk   (clk),
        .en    (adv),
        .probe (pixel.probe_red),
        .cand  (pixel.cand_red),
        .sq    (sq_r)
    );

    mpbfs_sq_lane #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_lane_g (
        .clk   (clk),
        .en    (adv),
        .probe (pixel.probe_green),
        .cand  (pixel.cand_green),
        .sq    (sq_g)
    );

    mpbfs_sq_lane #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_lane_b (
        .clk   (clk),
        .en    (adv),
        .probe (pixel.probe_blue),
        .cand  (pixel.cand_blue),
        .sq    (sq_b)
    );

    // lane sum, patch accumulation and best frame tracking
    mpbfs_merge #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .s1_valid    (s1_valid_reg),
        .s1_ctrl     (s1_ctrl_reg),
        .sq_r        (sq_r),
        .sq_g        (sq_g),
        .sq_b        (sq_b),
        .start_load  (cfg_we),
        .start_frame (start_sel),
        .stat        (stat),
        .res         (res),
        .res_strobe  (res_strobe)
    );

    // result register: a new result may land in the cycle the old one is taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_strobe)
        begin
            res_valid_next = 1'b1;
            res_next       = res;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.best_frame = res_reg.best_frame;
    assign result.best_error = res_reg.best_error;
    assign result.found      = res_reg.found;

endmodule

// ===== rtl/core/mpbfs_check.sv =====
module mpbfs_check
    import mpbfs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pix_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [FRAME_W-1:0] best_frame,
    input logic [ERR_W-1:0]   best_error,
    input logic               found
);

    // a waiting result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(best_frame)
            && $stable(best_error) && $stable(found))
        else $error("result changed while stalled");

    // empty search reports the neutral values
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> best_frame == '0 && best_error == ERR_EMPTY)
        else $error("empty search result not neutral");

    // a winning frame is strictly below the empty value
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && found |-> best_error != ERR_EMPTY)
        else $error("found frame with empty error");

    // input side stalls only behind an untaken result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> res_valid && !res_ready)
        else $error("input stalled without waiting result");

endmodule

bind masked_patch_best_frame_search_core mpbfs_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_ready  (pixel.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .best_frame (result.best_frame),
    .best_error (result.best_error),
    .found      (result.found)
);
